// ===== hw/rtl/dpid_pkg.sv =====
// Shared types, register indexes and widths of the depth PID controller.
`default_nettype none

package dpid_pkg;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_INTERVAL = 3'd4;

  localparam logic [31:0] PROP_GAIN_RST      = 32'd393216;
  localparam logic [31:0] DERIV_GAIN_RST     = 32'd0;
  localparam logic [31:0] INTEG_GAIN_RST     = 32'd0;
  localparam logic [30:0] INTEGRAL_LIMIT_RST = 31'd327680;
  localparam logic [15:0] FIRST_INTERVAL_RST = 16'd100;

  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Serial multiplier: 33 by 33 bit signed operands, radix-4 digits.
  localparam int OPD_W      = 33;
  localparam int PROD_W     = 2 * OPD_W;
  localparam int MUL_DIGITS = (OPD_W + 1) / 2;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

  // Serial divider: 32-bit magnitudes, one quotient bit per cycle.
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int FRAC_W = 16;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] target_depth;
    logic signed [31:0] measured_depth;
    logic signed [31:0] target_rate;
    logic        [31:0] time_ms;
  } pid_in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               saturated;
  } pid_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dpid_mul.sv =====
// Radix-4 digit-serial signed multiplier shared by all products of a step.
`default_nettype none

module dpid_mul import dpid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OPD_W-1:0]  a,
  input  logic [OPD_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam int HI_W = OPD_W + 3;
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PREP = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;
  localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(MUL_DIGITS - 1);

  logic [1:0]           ph_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [OPD_W-1:0]     m_r;
  logic [OPD_W+1:0]     m3_r;
  logic [OPD_W:0]       bq_r;
  logic [HI_W-1:0]      hi_r;
  logic [OPD_W:0]       lo_r;
  logic [HI_W-1:0]      m_ext;
  logic [HI_W-1:0]      dm;
  logic [HI_W-1:0]      hi_sum;

  assign m_ext = {{3{m_r[OPD_W-1]}}, m_r};

  // The top digit of the sign-extended multiplier holds two copies of the
  // sign bit, so it is worth minus the multiplicand or nothing.
  always_comb begin
    if (cnt_r == CNT_LAST) begin
      dm = bq_r[0] ? (~m_ext + HI_W'(1)) : '0;
    end else begin
      case (bq_r[1:0])
        2'd0:    dm = '0;
        2'd1:    dm = m_ext;
        2'd2:    dm = {{2{m_r[OPD_W-1]}}, m_r, 1'b0};
        default: dm = {m3_r[OPD_W+1], m3_r};
      endcase
    end
  end

  assign hi_sum = hi_r + dm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        PH_IDLE: begin
          if (start) begin
            ph_r <= PH_PREP;
          end
        end
        PH_PREP: begin
          cnt_r <= '0;
          ph_r  <= PH_RUN;
        end
        PH_RUN: begin
          cnt_r <= cnt_r + MUL_CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            ph_r   <= PH_IDLE;
            done_r <= 1'b1;
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ph_r)
      PH_IDLE: begin
        if (start) begin
          m_r  <= a;
          bq_r <= {b[OPD_W-1], b};
        end
      end
      PH_PREP: begin
        m3_r <= {{2{m_r[OPD_W-1]}}, m_r} + {m_r[OPD_W-1], m_r, 1'b0};
        hi_r <= '0;
        lo_r <= '0;
      end
      PH_RUN: begin
        hi_r <= {{2{hi_sum[HI_W-1]}}, hi_sum[HI_W-1:2]};
        lo_r <= {hi_sum[1:0], lo_r[OPD_W:2]};
        bq_r <= {2'b00, bq_r[OPD_W:2]};
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign prod = {hi_r[PROD_W-OPD_W-2:0], lo_r};

endmodule

`default_nettype wire

// ===== hw/rtl/dpid_div.sv =====
// Restoring bit-serial divider for the depth rate, truncating toward zero.
`default_nettype none

module dpid_div import dpid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W:0]   dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic             neg,
  output logic [DIV_W-1:0] quot
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 neg_r;
  logic [DIV_W-1:0]     d_r;
  logic [DIV_W-1:0]     r_r;
  logic [DIV_W-1:0]     q_r;
  logic [DIV_W:0]       mag;
  logic [DIV_W:0]       rs;
  logic [DIV_W+1:0]     trial;

  // The difference of two 32-bit depths always has a 32-bit magnitude.
  assign mag   = dividend[DIV_W] ? (~dividend + (DIV_W+1)'(1)) : dividend;
  assign rs    = {r_r, q_r[DIV_W-1]};
  assign trial = {1'b0, rs} - {2'b00, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DIV_W];
      d_r   <= divisor;
      r_r   <= '0;
      q_r   <= mag[DIV_W-1:0];
    end else if (busy_r) begin
      if (!trial[DIV_W+1]) begin
        r_r <= trial[DIV_W-1:0];
        q_r <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        r_r <= rs[DIV_W-1:0];
        q_r <= {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign neg  = neg_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// ===== hw/rtl/depth_pid_controller.sv =====
// Top level of the depth PID controller: registers, sequencer and output stage.
`default_nettype none

// Depth PID controller in signed Q16.16. A control step transaction makes
// four passes through the one shared radix-4 multiplier (error times
// interval and the three gain products), with the rate divider running
// alongside the first two passes, before its result appears on the output.
// A clear transaction gives no result. A new transaction is taken as soon
// as the sequencer is idle, even while the previous result is still
// waiting in the output register. Configuration writes are always taken and
// must only be issued while the block is idle; unknown indexes are ignored.
module depth_pid_controller import dpid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pid_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pid_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MINT   = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_MPROP  = 4'd3;
  localparam logic [3:0] S_WDIV   = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_MDER   = 4'd6;
  localparam logic [3:0] S_MINTG  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam int IP_W  = 34;
  localparam int SUM_W = PROD_W - FRAC_W + 2;

  localparam logic signed [PROD_W-1:0] IP_MAX = PROD_W'(64'sd4294967296);
  localparam logic signed [PROD_W-1:0] IP_MIN = -IP_MAX;
  localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;

  logic [3:0]  state_r, state_nxt;

  logic [31:0] prop_gain_r, deriv_gain_r, integ_gain_r;
  logic [30:0] limit_r;
  logic [15:0] first_ms_r;

  logic [31:0] prev_depth_r, prev_time_r, acc_r;
  logic        have_prev_r;

  logic [31:0] interval_r, trate_r, rate_r;
  logic [32:0] err_r;
  logic        upd_r;
  logic [IP_W-1:0]  ip_r;
  logic [SUM_W-1:0] sum_r;

  logic     out_valid_r;
  pid_out_t out_data_r;

  logic        step_acc, clr_acc, out_load;
  logic [32:0] in_err, in_diff;
  logic [31:0] in_interval;

  logic              mul_start, mul_done;
  logic [OPD_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic [SUM_W-1:0]  term;

  logic             div_done, div_neg;
  logic [DIV_W-1:0] div_quot;

  logic [IP_W-1:0] ip_nxt;
  logic [IP_W:0]   psum, lim, acc_clamp;
  logic [31:0]     rate_nxt;
  logic            clip_hi, clip_lo;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign step_acc  = in_valid && in_ready && (in_data.kind == KIND_STEP);
  assign clr_acc   = in_valid && in_ready && (in_data.kind == KIND_CLEAR);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign in_err  = {in_data.target_depth[31], in_data.target_depth}
                 - {in_data.measured_depth[31], in_data.measured_depth};
  assign in_diff = {in_data.measured_depth[31], in_data.measured_depth}
                 - {prev_depth_r[31], prev_depth_r};
  assign in_interval = have_prev_r ? (in_data.time_ms - prev_time_r)
                                   : {16'h0000, first_ms_r};

  // Operand selection for the shared multiplier, one product per state.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = err_r;
    mul_b     = '0;
    case (state_r)
      S_IDLE: begin
        mul_start = step_acc;
        mul_a     = in_err;
        mul_b     = {1'b0, in_interval};
      end
      S_ACC: begin
        mul_start = 1'b1;
        mul_a     = err_r;
        mul_b     = {prop_gain_r[31], prop_gain_r};
      end
      S_DSTART: begin
        mul_start = 1'b1;
        mul_a     = {trate_r[31], trate_r} - {rate_r[31], rate_r};
        mul_b     = {deriv_gain_r[31], deriv_gain_r};
      end
      S_MDER: begin
        mul_start = mul_done;
        mul_a     = {acc_r[31], acc_r};
        mul_b     = {integ_gain_r[31], integ_gain_r};
      end
      default: ;
    endcase
  end

  dpid_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  dpid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (step_acc),
    .dividend (in_diff),
    .divisor  (in_interval),
    .done     (div_done),
    .neg      (div_neg),
    .quot     (div_quot)
  );

  // Dropping the 16 fraction bits of a two's complement product is a floor.
  assign term = {{2{mul_prod[PROD_W-1]}}, mul_prod[PROD_W-1:FRAC_W]};

  always_comb begin
    if ($signed(mul_prod) > IP_MAX) begin
      ip_nxt = IP_MAX[IP_W-1:0];
    end else if ($signed(mul_prod) < IP_MIN) begin
      ip_nxt = IP_MIN[IP_W-1:0];
    end else begin
      ip_nxt = mul_prod[IP_W-1:0];
    end
  end

  assign psum = {ip_r[IP_W-1], ip_r} + {{(IP_W-31){acc_r[31]}}, acc_r};
  assign lim  = {{(IP_W-30){1'b0}}, limit_r};

  always_comb begin
    if ($signed(psum) > $signed(lim)) begin
      acc_clamp = lim;
    end else if ($signed(psum) < -$signed(lim)) begin
      acc_clamp = -lim;
    end else begin
      acc_clamp = psum;
    end
  end

  always_comb begin
    if (interval_r == 32'd0) begin
      rate_nxt = 32'd0;
    end else if (!div_neg) begin
      rate_nxt = div_quot[31] ? INT32_MAX : div_quot;
    end else begin
      rate_nxt = (div_quot > INT32_MIN) ? INT32_MIN : (~div_quot + 32'd1);
    end
  end

  assign clip_hi = !sum_r[SUM_W-1] && (|sum_r[SUM_W-2:31]);
  assign clip_lo = sum_r[SUM_W-1] && !(&sum_r[SUM_W-2:31]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (step_acc) state_nxt = S_MINT;
      S_MINT:   if (mul_done) state_nxt = S_ACC;
      S_ACC:    state_nxt = S_MPROP;
      S_MPROP:  if (mul_done) state_nxt = S_WDIV;
      S_WDIV:   if (div_done) state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_MDER;
      S_MDER:   if (mul_done) state_nxt = S_MINTG;
      S_MINTG:  if (mul_done) state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prop_gain_r  <= PROP_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      limit_r      <= INTEGRAL_LIMIT_RST;
      first_ms_r   <= FIRST_INTERVAL_RST;
      prev_depth_r <= '0;
      prev_time_r  <= '0;
      have_prev_r  <= 1'b0;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:      prop_gain_r  <= cfg_data;
          REG_DERIV_GAIN:     deriv_gain_r <= cfg_data;
          REG_INTEG_GAIN:     integ_gain_r <= cfg_data;
          REG_INTEGRAL_LIMIT: limit_r      <= cfg_data[30:0];
          REG_FIRST_INTERVAL: first_ms_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (step_acc) begin
        prev_depth_r <= in_data.measured_depth;
        prev_time_r  <= in_data.time_ms;
        have_prev_r  <= 1'b1;
      end
      if (clr_acc) begin
        acc_r <= '0;
      end else if (state_r == S_ACC && upd_r) begin
        acc_r <= acc_clamp[31:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_acc) begin
      interval_r <= in_interval;
      err_r      <= in_err;
      trate_r    <= in_data.target_rate;
      upd_r      <= (in_interval != 32'd0) && (in_err != 33'd0);
    end
    if (state_r == S_MINT && mul_done) begin
      ip_r <= ip_nxt;
    end
    if (state_r == S_MPROP && mul_done) begin
      sum_r <= term;
    end else if ((state_r == S_MDER || state_r == S_MINTG) && mul_done) begin
      sum_r <= sum_r + term;
    end
    if (state_r == S_WDIV && div_done) begin
      rate_r <= rate_nxt;
    end
    if (out_load) begin
      out_data_r.saturated <= clip_hi || clip_lo;
      if (clip_hi) begin
        out_data_r.drive <= INT32_MAX;
      end else if (clip_lo) begin
        out_data_r.drive <= INT32_MIN;
      end else begin
        out_data_r.drive <= sum_r[31:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
